>>> src/cbss_pkg.sv
// Package: request codes and transfer payload types for the substring search unit.
`default_nettype none

package cbss_pkg;

    localparam int IDX_W = 9;
    localparam int BYTE_W = 8;
    localparam int LEN_W = 6;
    localparam int POS_W = 9;

    localparam logic [1:0] REQ_WR_STORE = 2'd0;
    localparam logic [1:0] REQ_WR_PAT   = 2'd1;
    localparam logic [1:0] REQ_SEARCH   = 2'd2;
    localparam logic [1:0] REQ_CLEAR    = 2'd3;

    typedef struct packed {
        logic [1:0]        req_type;
        logic [IDX_W-1:0]  index;
        logic [BYTE_W-1:0] data_byte;
        logic [LEN_W-1:0]  pattern_length;
    } req_t;

    typedef struct packed {
        logic             found;
        logic [POS_W-1:0] match_position;
    } rsp_t;

endpackage

`default_nettype wire

>>> src/cbss_ram.sv
// Generic single-port-write, single-port-read RAM with registered read data.
`default_nettype none

module cbss_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 512
) (
    input  wire logic                     clk,
    input  wire logic                     we,
    input  wire logic [$clog2(DEPTH)-1:0] waddr,
    input  wire logic [WIDTH-1:0]         wdata,
    input  wire logic [$clog2(DEPTH)-1:0] raddr,
    output logic      [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata <= mem[raddr];
    end

endmodule

`default_nettype wire

>>> src/circular_buffer_substring_search_unit.sv
// Top level: circular receive store with first-occurrence pattern search.
// Store and pattern writes: one transfer per cycle while the unit is idle, no response.
// Clear: one store entry zeroed per cycle over all BUF_DEPTH entries; request side stalls meanwhile.
// Search: each byte compare is a RAM read state, then a compare state; the result is then
//   loaded into the response register; an empty pattern goes straight to the response load.
// Reset is asynchronous active low; afterwards all BUF_DEPTH store entries are zeroed
//   before the first request is taken. Pattern entries are undefined until written.
`default_nettype none

module circular_buffer_substring_search_unit #(
    parameter int BUF_DEPTH = 512,
    parameter int PAT_MAX = 32
) (
    input  wire logic          clk,
    input  wire logic          rst_n,
    input  wire logic          req_valid,
    output logic               req_ready,
    input  wire cbss_pkg::req_t req_data,
    output logic               rsp_valid,
    input  wire logic          rsp_ready,
    output cbss_pkg::rsp_t     rsp_data
);

    localparam int AW = $clog2(BUF_DEPTH);
    localparam int PW = $clog2(PAT_MAX);
    localparam int LW = $clog2(PAT_MAX + 1);
    localparam int MOD_STEPS = $clog2((1 << cbss_pkg::IDX_W) / BUF_DEPTH + 1);

    typedef enum logic [4:0] {
        ST_IDLE  = 5'b00001,
        ST_CLEAR = 5'b00010,
        ST_READ  = 5'b00100,
        ST_CMP   = 5'b01000,
        ST_DONE  = 5'b10000
    } state_t;

    state_t                  state_reg, state_next;
    logic [AW-1:0]           clr_reg, clr_next;
    logic [AW-1:0]           start_reg, start_next;
    logic [AW-1:0]           addr_reg, addr_next;
    logic [LW-1:0]           k_reg, k_next;
    logic [LW-1:0]           len_reg, len_next;
    logic                    found_reg, found_next;
    logic                    rsp_valid_reg, rsp_valid_next;
    cbss_pkg::rsp_t          rsp_data_reg, rsp_data_next;

    logic                    req_xfer;
    logic                    rsp_load;
    logic [cbss_pkg::IDX_W-1:0] idx_rem;
    logic [AW-1:0]           idx_mod;
    logic [LW-1:0]           len_sat;

    logic                    st_we;
    logic [AW-1:0]           st_waddr;
    logic [7:0]              st_wdata;
    logic [7:0]              st_rdata;
    logic                    pt_we;
    logic [7:0]              pt_rdata;

    assign req_ready = (state_reg == ST_IDLE);
    assign req_xfer  = req_valid && req_ready;
    assign rsp_valid = rsp_valid_reg;
    assign rsp_data  = rsp_data_reg;
    assign rsp_load  = (state_reg == ST_DONE) && (!rsp_valid_reg || rsp_ready);

    // index modulo BUF_DEPTH by restoring subtraction
    always_comb
    begin
        idx_rem = req_data.index;
        for (int s = MOD_STEPS - 1; s >= 0; s--)
        begin
            if (32'(idx_rem) >= (BUF_DEPTH << s))
            begin
                idx_rem = idx_rem - cbss_pkg::IDX_W'(BUF_DEPTH << s);
            end
        end
        idx_mod = AW'(idx_rem);
    end

    always_comb
    begin
        if (32'(req_data.pattern_length) > PAT_MAX)
        begin
            len_sat = LW'(PAT_MAX);
        end
        else
        begin
            len_sat = LW'(req_data.pattern_length);
        end
    end

    always_comb
    begin
        st_we    = 1'b0;
        st_waddr = idx_mod;
        st_wdata = req_data.data_byte;
        pt_we    = 1'b0;
        if (state_reg == ST_CLEAR)
        begin
            st_we    = 1'b1;
            st_waddr = clr_reg;
            st_wdata = 8'd0;
        end
        else if (req_xfer && req_data.req_type == cbss_pkg::REQ_WR_STORE)
        begin
            st_we = 1'b1;
        end
        if (req_xfer && req_data.req_type == cbss_pkg::REQ_WR_PAT
            && 32'(req_data.index) < PAT_MAX)
        begin
            pt_we = 1'b1;
        end
    end

    always_comb
    begin
        state_next     = state_reg;
        clr_next       = clr_reg;
        start_next     = start_reg;
        addr_next      = addr_reg;
        k_next         = k_reg;
        len_next       = len_reg;
        found_next     = found_reg;
        rsp_valid_next = rsp_valid_reg;
        rsp_data_next  = rsp_data_reg;

        if (rsp_ready)
        begin
            rsp_valid_next = 1'b0;
        end

        case (state_reg)
            ST_IDLE:
            begin
                if (req_xfer)
                begin
                    case (req_data.req_type)
                        cbss_pkg::REQ_SEARCH:
                        begin
                            start_next = '0;
                            addr_next  = '0;
                            k_next     = '0;
                            len_next   = len_sat;
                            found_next = 1'b0;
                            state_next = (len_sat == '0) ? ST_DONE : ST_READ;
                        end
                        cbss_pkg::REQ_CLEAR:
                        begin
                            clr_next   = '0;
                            state_next = ST_CLEAR;
                        end
                        default:
                        begin
                            state_next = ST_IDLE;
                        end
                    endcase
                end
            end
            ST_CLEAR:
            begin
                clr_next = AW'(clr_reg + 1'b1);
                if (32'(clr_reg) == BUF_DEPTH - 1)
                begin
                    state_next = ST_IDLE;
                end
            end
            ST_READ:
            begin
                state_next = ST_CMP;
            end
            ST_CMP:
            begin
                if (st_rdata == pt_rdata)
                begin
                    if (LW'(k_reg + 1'b1) == len_reg)
                    begin
                        found_next = 1'b1;
                        state_next = ST_DONE;
                    end
                    else
                    begin
                        k_next     = LW'(k_reg + 1'b1);
                        addr_next  = (32'(addr_reg) == BUF_DEPTH - 1) ? '0
                                                                      : AW'(addr_reg + 1'b1);
                        state_next = ST_READ;
                    end
                end
                else if (32'(start_reg) == BUF_DEPTH - 1)
                begin
                    state_next = ST_DONE;
                end
                else
                begin
                    start_next = AW'(start_reg + 1'b1);
                    addr_next  = AW'(start_reg + 1'b1);
                    k_next     = '0;
                    state_next = ST_READ;
                end
            end
            ST_DONE:
            begin
                if (rsp_load)
                begin
                    rsp_valid_next               = 1'b1;
                    rsp_data_next.found          = found_reg;
                    rsp_data_next.match_position = found_reg ? cbss_pkg::POS_W'(start_reg)
                                                             : '0;
                    state_next                   = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_CLEAR;
            clr_reg       <= '0;
            rsp_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            clr_reg       <= clr_next;
            rsp_valid_reg <= rsp_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        start_reg    <= start_next;
        addr_reg     <= addr_next;
        k_reg        <= k_next;
        len_reg      <= len_next;
        found_reg    <= found_next;
        rsp_data_reg <= rsp_data_next;
    end

    cbss_ram #(
        .WIDTH (8),
        .DEPTH (BUF_DEPTH)
    ) u_store_ram (
        .clk   (clk),
        .we    (st_we),
        .waddr (st_waddr),
        .wdata (st_wdata),
        .raddr (addr_reg),
        .rdata (st_rdata)
    );

    cbss_ram #(
        .WIDTH (8),
        .DEPTH (PAT_MAX)
    ) u_pattern_ram (
        .clk   (clk),
        .we    (pt_we),
        .waddr (req_data.index[PW-1:0]),
        .wdata (req_data.data_byte),
        .raddr (k_reg[PW-1:0]),
        .rdata (pt_rdata)
    );

endmodule

`default_nettype wire

>>> src/cbss_checker.sv
// Port-level checker for the substring search unit, bound to the top level.
`default_nettype none

module cbss_checker (
    input wire logic           clk,
    input wire logic           rst_n,
    input wire logic           req_valid,
    input wire logic           req_ready,
    input wire cbss_pkg::req_t req_data,
    input wire logic           rsp_valid,
    input wire logic           rsp_ready,
    input wire cbss_pkg::rsp_t rsp_data
);

    // stalled response holds
    assert property (@(posedge clk) disable iff (!rst_n)
        rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp_data))
        else $error("response changed while stalled");

    assert property (@(posedge clk) disable iff (!rst_n)
        rsp_valid && !rsp_data.found |-> rsp_data.match_position == '0)
        else $error("nonzero position without a match");

    // writes and clears never produce a response
    assert property (@(posedge clk) disable iff (!rst_n)
        req_valid && req_ready && !rsp_valid
        && req_data.req_type != cbss_pkg::REQ_SEARCH |=> !rsp_valid)
        else $error("response without a search");

    // search and clear occupy the unit
    assert property (@(posedge clk) disable iff (!rst_n)
        req_valid && req_ready && (req_data.req_type == cbss_pkg::REQ_SEARCH
        || req_data.req_type == cbss_pkg::REQ_CLEAR) |=> !req_ready)
        else $error("request taken while busy");

endmodule

bind circular_buffer_substring_search_unit cbss_checker u_cbss_checker (
    .clk       (clk),
    .rst_n     (rst_n),
    .req_valid (req_valid),
    .req_ready (req_ready),
    .req_data  (req_data),
    .rsp_valid (rsp_valid),
    .rsp_ready (rsp_ready),
    .rsp_data  (rsp_data)
);

`default_nettype wire

>>> tb/sv/cbss_search_checker.sv
// Checker: watches both channels, predicts search results and compares them.
`timescale 1ns / 1ps

module cbss_search_checker (
    input  wire logic           clk,
    input  wire logic           rst_n,
    input  wire logic           req_valid,
    input  wire logic           req_ready,
    input  wire cbss_pkg::req_t req_data,
    input  wire logic           rsp_valid,
    input  wire logic           rsp_ready,
    input  wire cbss_pkg::rsp_t rsp_data,
    output int                  errors,
    output int                  pending,
    output int                  checked,
    output int                  hits
);
    import cbss_pkg::*;

    localparam int DEPTH_N = 512;
    localparam int PAT_N = 32;

    logic [BYTE_W-1:0] rx_img [DEPTH_N];
    logic [BYTE_W-1:0] pat_img [PAT_N];
    rsp_t              due_q [$];
    rsp_t              want;
    int                err_n = 0;
    int                chk_n = 0;
    int                hit_n = 0;

    initial
    begin
        errors = 0;
        pending = 0;
        checked = 0;
        hits = 0;
        for (int i = 0; i < DEPTH_N; i++)
        begin
            rx_img[i] = '0;
        end
        for (int i = 0; i < PAT_N; i++)
        begin
            pat_img[i] = '0;
        end
    end

    function automatic rsp_t search_image(input logic [LEN_W-1:0] len_field);
        int   n;
        bit   hit;
        rsp_t r;
        n = (len_field > PAT_N) ? PAT_N : int'(len_field);
        r = '0;
        if (n != 0)
        begin
            for (int s = 0; s < DEPTH_N; s++)
            begin
                hit = 1'b1;
                for (int k = 0; k < n; k++)
                begin
                    if (rx_img[(s + k) % DEPTH_N] != pat_img[k])
                    begin
                        hit = 1'b0;
                        break;
                    end
                end
                if (hit)
                begin
                    r.found = 1'b1;
                    r.match_position = s[POS_W-1:0];
                    break;
                end
            end
        end
        return r;
    endfunction

    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if (rsp_valid && rsp_ready)
            begin
                if (due_q.size() == 0)
                begin
                    err_n++;
                    $display("%0t: unexpected result transfer, expected none, actual found=%0d pos=%0d",
                             $time, rsp_data.found, rsp_data.match_position);
                end
                else
                begin
                    want = due_q.pop_front();
                    chk_n++;
                    if (want.found)
                    begin
                        hit_n++;
                    end
                    if (rsp_data.found !== want.found)
                    begin
                        err_n++;
                        $display("%0t: found mismatch, expected %0d actual %0d",
                                 $time, want.found, rsp_data.found);
                    end
                    if (rsp_data.match_position !== want.match_position)
                    begin
                        err_n++;
                        $display("%0t: match_position mismatch, expected %0d actual %0d",
                                 $time, want.match_position, rsp_data.match_position);
                    end
                end
            end
            if (req_valid && req_ready)
            begin
                case (req_data.req_type)
                    REQ_WR_STORE:
                    begin
                        rx_img[req_data.index] = req_data.data_byte;
                    end
                    REQ_WR_PAT:
                    begin
                        if (req_data.index < PAT_N)
                        begin
                            pat_img[req_data.index[4:0]] = req_data.data_byte;
                        end
                    end
                    REQ_CLEAR:
                    begin
                        for (int i = 0; i < DEPTH_N; i++)
                        begin
                            rx_img[i] = '0;
                        end
                    end
                    default:
                    begin
                        due_q.push_back(search_image(req_data.pattern_length));
                    end
                endcase
            end
            errors <= err_n;
            pending <= due_q.size();
            checked <= chk_n;
            hits <= hit_n;
        end
    end

endmodule

>>> tb/sv/circular_buffer_substring_search_unit_tb.sv
// Testbench top: clock, reset, request stimulus, response stalls and verdict.
`timescale 1ns / 1ps

module circular_buffer_substring_search_unit_tb;
    import cbss_pkg::*;

    localparam int PAT_N = 32;
    localparam int DEPTH_N = 512;
    localparam int ITEMS = 1600;
    localparam int IDLE_LIMIT = 200000;
    localparam int HOLD_CYCLES = 300;

    logic   clk = 1'b0;
    logic   rst_n = 1'b0;
    logic   req_valid = 1'b0;
    req_t   req_data = '0;
    logic   rsp_ready = 1'b0;
    logic   hold_req = 1'b0;
    wire    req_ready;
    wire    rsp_valid;
    rsp_t   rsp_data;

    int     errors;
    int     pending;
    int     checked;
    int     hits;

    int     burst_left = 0;
    int     work = 0;
    int     clears = 0;
    logic [PAT_N-1:0] pat_ok = '0;

    int     idle_cycles = 0;
    bit     hold_taken = 1'b0;
    int     hold_left = 0;
    int     mode = 0;
    int     mode_left = 0;

    always #5 clk = ~clk;

    circular_buffer_substring_search_unit i_dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .req_valid (req_valid),
        .req_ready (req_ready),
        .req_data  (req_data),
        .rsp_valid (rsp_valid),
        .rsp_ready (rsp_ready),
        .rsp_data  (rsp_data)
    );

    cbss_search_checker i_checker (
        .clk       (clk),
        .rst_n     (rst_n),
        .req_valid (req_valid),
        .req_ready (req_ready),
        .req_data  (req_data),
        .rsp_valid (rsp_valid),
        .rsp_ready (rsp_ready),
        .rsp_data  (rsp_data),
        .errors    (errors),
        .pending   (pending),
        .checked   (checked),
        .hits      (hits)
    );

    // receiver: long hold-off once, otherwise stretches of different stall rates
    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if (hold_req && !hold_taken)
            begin
                hold_taken = 1'b1;
                hold_left = HOLD_CYCLES;
            end
            if (hold_left != 0)
            begin
                hold_left--;
                rsp_ready <= 1'b0;
            end
            else
            begin
                if (mode_left == 0)
                begin
                    mode = $urandom_range(0, 2);
                    mode_left = $urandom_range(16, 160);
                end
                mode_left--;
                case (mode)
                    0:       rsp_ready <= 1'b1;
                    1:       rsp_ready <= $urandom_range(0, 1);
                    default: rsp_ready <= ($urandom_range(0, 3) == 0);
                endcase
            end
        end
    end

    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if ((req_valid && req_ready) || (rsp_valid && rsp_ready))
            begin
                idle_cycles = 0;
            end
            else
            begin
                idle_cycles++;
                if (idle_cycles >= IDLE_LIMIT)
                begin
                    $display("circular_buffer_substring_search_unit_tb: errors");
                    $finish;
                end
            end
        end
    end

    function automatic req_t mk_req(input logic [1:0] t, input logic [IDX_W-1:0] i,
                                    input logic [BYTE_W-1:0] d, input logic [LEN_W-1:0] n);
        req_t r;
        r.req_type = t;
        r.index = i;
        r.data_byte = d;
        r.pattern_length = n;
        return r;
    endfunction

    function automatic int safe_len();
        int n;
        n = 0;
        while (n < PAT_N && pat_ok[n])
        begin
            n++;
        end
        return n;
    endfunction

    task automatic put_req(input req_t r);
        if (burst_left == 0)
        begin
            req_valid <= 1'b0;
            repeat ($urandom_range(1, 12)) @(posedge clk);
            burst_left = ($urandom_range(0, 3) == 0) ? $urandom_range(40, 200)
                                                      : $urandom_range(1, 10);
        end
        req_valid <= 1'b1;
        req_data <= r;
        @(posedge clk);
        while (!req_ready) @(posedge clk);
        burst_left--;
        if (!(r.req_type == REQ_WR_PAT && r.index >= PAT_N))
        begin
            work++;
        end
        if (r.req_type == REQ_WR_PAT && r.index < PAT_N)
        begin
            pat_ok[r.index[4:0]] = 1'b1;
        end
        if (r.req_type == REQ_CLEAR)
        begin
            clears++;
        end
    endtask

    task automatic drain();
        req_valid <= 1'b0;
        do @(posedge clk); while (pending != 0);
        burst_left = $urandom_range(1, 10);
    endtask

    task automatic scatter_writes(input int count);
        req_t r;
        for (int i = 0; i < count; i++)
        begin
            r = mk_req(REQ_WR_STORE, $urandom_range(0, DEPTH_N - 1), $urandom_range(0, 255),
                       $urandom_range(0, 63));
            if ($urandom_range(0, 4) == 0)
            begin
                r.req_type = REQ_WR_PAT;
                r.index = $urandom_range(0, 1) ? $urandom_range(0, PAT_N - 1)
                                               : $urandom_range(0, DEPTH_N - 1);
            end
            put_req(r);
        end
    endtask

    task automatic random_search();
        int   n;
        logic [LEN_W-1:0] len;
        n = safe_len();
        len = (n == PAT_N && $urandom_range(0, 1)) ? $urandom_range(0, 63) : $urandom_range(0, n);
        put_req(mk_req(REQ_SEARCH, $urandom_range(0, DEPTH_N - 1), $urandom_range(0, 255), len));
    endtask

    // write a pattern, maybe plant it in the store (once or twice, maybe across the wrap), search
    task automatic plant_and_search(input bit force_long);
        int   plen;
        int   base;
        int   copies;
        bit   narrow;
        logic [LEN_W-1:0] len;
        logic [BYTE_W-1:0] pat [PAT_N];
        plen = ($urandom_range(0, 9) == 0) ? $urandom_range(17, PAT_N) : $urandom_range(1, 8);
        if (force_long)
        begin
            plen = PAT_N;
        end
        narrow = $urandom_range(0, 1);
        for (int k = 0; k < plen; k++)
        begin
            if (narrow)
            begin
                case ($urandom_range(0, 2))
                    0:       pat[k] = 8'h00;
                    1:       pat[k] = 8'h41;
                    default: pat[k] = 8'hFF;
                endcase
            end
            else
            begin
                pat[k] = $urandom_range(0, 255);
            end
            put_req(mk_req(REQ_WR_PAT, k, pat[k], $urandom_range(0, 63)));
        end
        copies = ($urandom_range(0, 3) == 0) ? 0 : (($urandom_range(0, 4) == 0) ? 2 : 1);
        for (int c = 0; c < copies; c++)
        begin
            base = ($urandom_range(0, 4) == 0) ? DEPTH_N - $urandom_range(1, plen)
                                               : $urandom_range(0, DEPTH_N - 1);
            for (int k = 0; k < plen; k++)
            begin
                put_req(mk_req(REQ_WR_STORE, (base + k) % DEPTH_N, pat[k], $urandom_range(0, 63)));
            end
        end
        len = plen;
        if (plen == PAT_N && $urandom_range(0, 1))
        begin
            len = $urandom_range(PAT_N, 63);
        end
        else if ($urandom_range(0, 4) == 0)
        begin
            len = $urandom_range(1, plen);
        end
        if (force_long)
        begin
            len = 6'd63;
        end
        put_req(mk_req(REQ_SEARCH, $urandom_range(0, DEPTH_N - 1), $urandom_range(0, 255), len));
    endtask

    initial
    begin
        int  pick;
        bit  first;
        bit  held;
        bit  drained;
        first = 1'b1;
        held = 1'b0;
        drained = 1'b0;

        repeat (12) @(posedge clk);
        rst_n <= 1'b1;

        put_req(mk_req(REQ_SEARCH, 9'd0, 8'h00, 6'd0));
        put_req(mk_req(REQ_WR_PAT, 9'd0, 8'h00, 6'd0));
        put_req(mk_req(REQ_SEARCH, 9'd0, 8'h00, 6'd1));
        put_req(mk_req(REQ_WR_STORE, 9'd511, 8'hFF, 6'd63));
        put_req(mk_req(REQ_WR_STORE, 9'd0, 8'hAB, 6'd0));
        put_req(mk_req(REQ_WR_PAT, 9'd0, 8'hFF, 6'd0));
        put_req(mk_req(REQ_WR_PAT, 9'd1, 8'hAB, 6'd0));
        put_req(mk_req(REQ_SEARCH, 9'd0, 8'h00, 6'd2));
        put_req(mk_req(REQ_WR_PAT, 9'd300, 8'h5A, 6'd0));
        put_req(mk_req(REQ_WR_PAT, 9'd32, 8'h5A, 6'd0));
        put_req(mk_req(REQ_SEARCH, 9'd511, 8'hFF, 6'd2));
        put_req(mk_req(REQ_WR_STORE, 9'd255, 8'hFF, 6'd0));
        put_req(mk_req(REQ_WR_STORE, 9'd256, 8'hAB, 6'd0));
        put_req(mk_req(REQ_SEARCH, 9'd0, 8'h00, 6'd2));
        put_req(mk_req(REQ_SEARCH, 9'd511, 8'hFF, 6'd1));
        put_req(mk_req(REQ_CLEAR, 9'd511, 8'hFF, 6'd63));
        put_req(mk_req(REQ_SEARCH, 9'd0, 8'h00, 6'd2));
        put_req(mk_req(REQ_WR_PAT, 9'd0, 8'h00, 6'd0));
        put_req(mk_req(REQ_SEARCH, 9'd0, 8'h00, 6'd1));
        put_req(mk_req(REQ_WR_STORE, 9'd0, 8'hFF, 6'd0));
        put_req(mk_req(REQ_WR_PAT, 9'd1, 8'hFF, 6'd0));
        put_req(mk_req(REQ_SEARCH, 9'd0, 8'h00, 6'd2));

        while (work < ITEMS)
        begin
            if (!held && work >= 400)
            begin
                held = 1'b1;
                hold_req <= 1'b1;
                for (int i = 0; i < 6; i++)
                begin
                    put_req(mk_req(REQ_SEARCH, $urandom_range(0, DEPTH_N - 1),
                                   $urandom_range(0, 255), 6'd0));
                end
                scatter_writes(4);
            end
            if (!drained && work >= 1000)
            begin
                drained = 1'b1;
                drain();
            end
            pick = $urandom_range(0, 99);
            if (first || pick < 55)
            begin
                plant_and_search(first);
                first = 1'b0;
            end
            else if (pick < 80)
            begin
                scatter_writes($urandom_range(1, 8));
            end
            else if (pick < 95)
            begin
                random_search();
            end
            else if (pick < 97)
            begin
                put_req(mk_req(REQ_CLEAR, $urandom_range(0, DEPTH_N - 1), $urandom_range(0, 255),
                               $urandom_range(0, 63)));
            end
            else
            begin
                drain();
            end
        end

        drain();
        repeat (2 * DEPTH_N + 100) @(posedge clk);

        $display("Run covered %0d requests with %0d clears; %0d search results checked, %0d hits.",
                 work, clears, checked, hits);
        $display("Included planted and wrapped patterns, saturated lengths, a long response stall and drains.");
        if (errors == 0 && pending == 0)
        begin
            $display("circular_buffer_substring_search_unit_tb: clean");
        end
        else
        begin
            $display("circular_buffer_substring_search_unit_tb: errors");
        end
        $finish;
    end

endmodule
